@@ src/pgtp_pkg.sv @@
// ----------------------------------------------------------------------------
// pgtp_pkg
// Shared types and constants of the trial-division prime generator.
// ----------------------------------------------------------------------------
package pgtp_pkg;

  // Width of the prime count, the prime index and the limit register.
  localparam int CNT_W = 11;

  // Configuration data width and register indexes.
  localparam int CFG_DATA_W      = 32;
  localparam int REG_PRIME_LIMIT = 0;
  localparam int LIMIT_RESET     = 1024;

  // The first candidate of a fresh sequence.
  localparam int CAND_START = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CAND,
    ST_FETCH,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RESULT
  } pgtp_state_t;

endpackage

@@ src/pgtp_if.sv @@
// ----------------------------------------------------------------------------
// pgtp_in_if / pgtp_out_if
// Valid/ready channels for requests and for generated primes.
// ----------------------------------------------------------------------------
interface pgtp_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface pgtp_out_if #(
  parameter int PRIME_WIDTH = 13
);
  logic                   valid;
  logic                   ready;
  logic [PRIME_WIDTH-1:0] prime;
  logic [10:0]            prime_index;
  logic                   exhausted;

  modport source (output valid, output prime, output prime_index, output exhausted,
                  input ready);
  modport sink   (input valid, input prime, input prime_index, input exhausted,
                  output ready);
endinterface

@@ src/pgtp_table.sv @@
// ----------------------------------------------------------------------------
// pgtp_table
// Single-port-write, registered-read memory that holds the primes found.
// ----------------------------------------------------------------------------
module pgtp_table #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 13,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/pgtp_divider.sv @@
// ----------------------------------------------------------------------------
// pgtp_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pgtp_divider #(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNTW = $clog2(W);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [W-1:0]    quo_r;
  logic [W-1:0]    rem_r;
  logic [W-1:0]    div_r;

  logic [W:0]      shifted;
  logic [W:0]      diff;
  logic            q_bit;

  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = shifted - {1'b0, div_r};
    q_bit   = (shifted >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[W-2:0], q_bit};
      rem_r <= q_bit ? diff[W-1:0] : shifted[W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ src/prime_gen_trial_by_primes.sv @@
// ----------------------------------------------------------------------------
// prime_gen_trial_by_primes
// Prime generator: trial division of each candidate by the primes found so far.
// ----------------------------------------------------------------------------
// Each request returns the next prime in ascending order, starting at 2, with
// its zero-based index; a request with restart set starts again from 2. After
// min(prime_limit, TABLE_DEPTH) primes, or when no prime of PRIME_WIDTH bits
// is left, a request returns exhausted with prime 0 and the current count.
// One request is handled at a time. The count is first checked against the
// limit; then each candidate is tried against the stored primes in order,
// one run of the bit-serial divider per stored prime, until a prime is found
// or the candidate outgrows PRIME_WIDTH bits. Larger primes take longer, as
// more stored primes are tried per candidate. The result waits in an output
// register, so the next request is taken while a result is still pending.
// ----------------------------------------------------------------------------
module prime_gen_trial_by_primes
  import pgtp_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int PRIME_WIDTH = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pgtp_in_if.sink               in_ch,
  pgtp_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = PRIME_WIDTH + 1;

  // --------------------------------------------------------------------------
  // Configuration. The register map has a single register, prime_limit at
  // address 0; only writes to that address land in it, and every read returns it.
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] limit_r;
  logic [CNT_W-1:0] eff_limit;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'(REG_PRIME_LIMIT));
  assign prdata = CFG_DATA_W'(limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CNT_W'(LIMIT_RESET);
    end else if (cfg_wr) begin
      limit_r <= pwdata[CNT_W-1:0];
    end
  end

  // The table cannot hold more primes than its depth.
  always_comb begin
    if (32'(limit_r) > TABLE_DEPTH) begin
      eff_limit = CNT_W'(TABLE_DEPTH);
    end else begin
      eff_limit = limit_r;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state.
  // found_r   : primes produced since reset or restart.
  // next_c_r  : first candidate of the next search.
  // work_r    : candidate under test; it only becomes next_c_r when a prime
  //             is found, so an exhausted search leaves the state untouched.
  // idx_r     : position in the table of the prime being tried.
  // res_exh_r : the pending result is an exhausted report.
  // --------------------------------------------------------------------------
  pgtp_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] found_r, found_nxt;
  logic [CW-1:0]    next_c_r, next_c_nxt;
  logic [CW-1:0]    work_r, work_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             res_exh_r, res_exh_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [PRIME_WIDTH-1:0] out_prime_r, out_prime_nxt;
  logic [CNT_W-1:0]       out_index_r, out_index_nxt;
  logic                   out_exh_r, out_exh_nxt;

  logic                   tbl_we;
  logic                   tbl_re;
  logic [PRIME_WIDTH-1:0] tbl_rdata;

  logic                   div_start;
  logic                   div_done;
  logic [PRIME_WIDTH-1:0] div_quo;
  logic [PRIME_WIDTH-1:0] div_rem;

  logic in_xfer;
  logic out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      found_r     <= '0;
      next_c_r    <= CW'(CAND_START);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      next_c_r    <= next_c_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    idx_r       <= idx_nxt;
    res_exh_r   <= res_exh_nxt;
    out_prime_r <= out_prime_nxt;
    out_index_r <= out_index_nxt;
    out_exh_r   <= out_exh_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    found_nxt     = found_r;
    next_c_nxt    = next_c_r;
    work_nxt      = work_r;
    idx_nxt       = idx_r;
    res_exh_nxt   = res_exh_r;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    out_index_nxt = out_index_r;
    out_exh_nxt   = out_exh_r;
    tbl_we        = 1'b0;
    tbl_re        = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.restart) begin
            found_nxt  = '0;
            next_c_nxt = CW'(CAND_START);
          end
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (found_r < eff_limit) begin
          work_nxt  = next_c_r;
          state_nxt = ST_CAND;
        end else begin
          res_exh_nxt = 1'b1;
          state_nxt   = ST_RESULT;
        end
      end

      // A candidate past the widest representable prime ends the search.
      ST_CAND: begin
        if (work_r[PRIME_WIDTH]) begin
          res_exh_nxt = 1'b1;
          state_nxt   = ST_RESULT;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_FETCH;
        end
      end

      // Running out of stored primes means no divisor was found.
      ST_FETCH: begin
        if (idx_r == found_r) begin
          res_exh_nxt = 1'b0;
          state_nxt   = ST_RESULT;
        end else begin
          tbl_re    = 1'b1;
          state_nxt = ST_DIV_GO;
        end
      end

      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end

      // With c = q*p + r and r < p, p*p > c holds exactly when q < p, so the
      // quotient gives the square-root bound with no multiplier.
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (div_quo < tbl_rdata) begin
            res_exh_nxt = 1'b0;
            state_nxt   = ST_RESULT;
          end else if (div_rem == '0) begin
            work_nxt  = work_r + 1'b1;
            state_nxt = ST_CAND;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_FETCH;
          end
        end
      end

      // Wait for room in the output register, then commit the result.
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = found_r;
          out_exh_nxt   = res_exh_r;
          if (res_exh_r) begin
            out_prime_nxt = '0;
          end else begin
            out_prime_nxt = work_r[PRIME_WIDTH-1:0];
            tbl_we        = 1'b1;
            found_nxt     = found_r + 1'b1;
            next_c_nxt    = work_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.prime       = out_prime_r;
  assign out_ch.prime_index = out_index_r;
  assign out_ch.exhausted   = out_exh_r;

  // --------------------------------------------------------------------------
  // Prime table and the single divider.
  // --------------------------------------------------------------------------
  pgtp_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (PRIME_WIDTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(found_r)),
    .wdata (work_r[PRIME_WIDTH-1:0]),
    .re    (tbl_re),
    .raddr (AW'(idx_r)),
    .rdata (tbl_rdata)
  );

  pgtp_divider #(
    .W (PRIME_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (work_r[PRIME_WIDTH-1:0]),
    .divisor   (tbl_rdata),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

endmodule

@@ tb/prime_gen_trial_by_primes_test.sv @@
// ----------------------------------------------------------------------------
// prime_gen_trial_by_primes_test
// Self-checking testbench for the trial-division prime generator.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver on the request channel, and a
// clocked monitor takes the generated primes off the result channel. Every
// accepted request runs through a local model of the generator, and the
// monitor checks each result field by field against the oldest prediction.
// A directed opening covers the first primes, restart, a limit of zero, a
// limit of one, a limit above the table depth and a write with the upper data
// bits set. The random part runs mostly restart-led request runs of random
// length under a range of limits, with some random restart noise mixed in,
// and random idling on both channels plus one long result-side hold-off.
// ----------------------------------------------------------------------------
module prime_gen_trial_by_primes_test;
  import pgtp_pkg::*;

  localparam int TABLE_N   = 1024;
  localparam int PRIME_W   = 13;
  localparam int PRIME_MAX = (1 << PRIME_W) - 1;

  // Number of segments in the random part and the one that holds off the
  // result channel for a long stretch.
  localparam int SEGMENTS      = 10;
  localparam int HOLD_SEGMENT  = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int SEGMENT_ITEMS = 110;

  // One generated prime as it leaves the block.
  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [CNT_W-1:0]   prime_idx;
    logic               exhausted;
  } prime_result_t;

  logic clk;
  logic rst_n;

  // Configuration port.
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [1:0]            paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  pgtp_in_if                           in_if ();
  pgtp_out_if #(.PRIME_WIDTH(PRIME_W)) out_if ();

  prime_gen_trial_by_primes #(
    .TABLE_DEPTH(TABLE_N),
    .PRIME_WIDTH(PRIME_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Requests waiting for the driver, and primes predicted but not yet seen.
  bit            request_q[$];
  prime_result_t prime_expect_q[$];

  // Local copy of the generator state and of the limit register.
  int unsigned found_primes[TABLE_N];
  int          found_n;
  int          cand_next;
  int          limit_reg;

  // Idle rates in percent for each side, and the long hold-off flag.
  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold;
  int phase_id;

  // Bookkeeping.
  int n_pushed;
  int n_accepted;
  int n_errors;
  int n_primes;
  int n_exhausted;
  int n_restarts;
  int n_limit_writes;
  int max_idx_seen;

  // The clock toggles every half period of 4 units.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // True when candidate c has a stored prime factor no larger than its square
  // root. Only entries that have been filled in are looked at.
  function automatic bit has_stored_factor(int c);
    int unsigned p;
    for (int i = 0; i < found_n && i < TABLE_N; i++) begin
      p = found_primes[i];
      if (p < 2 || p * p > c)
        break;
      if (c % p == 0)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the reply to one accepted request and appends it to the
  // expectations. The effective limit is capped at the table depth. When the
  // count has reached it, or no prime of the result width is left, the reply
  // is exhausted with prime 0 and the current count as its index.
  function automatic void predict_prime(bit restart);
    int            lim;
    int            c;
    prime_result_t r;
    lim = (limit_reg > TABLE_N) ? TABLE_N : limit_reg;
    if (restart) begin
      found_n   = 0;
      cand_next = CAND_START;
    end
    r.prime     = '0;
    r.prime_idx = CNT_W'(found_n);
    r.exhausted = 1'b1;
    if (found_n < lim) begin
      c = (cand_next < 2) ? 2 : cand_next;
      while (c <= PRIME_MAX && has_stored_factor(c))
        c++;
      if (c <= PRIME_MAX) begin
        found_primes[found_n] = c;
        r.prime               = PRIME_W'(c);
        r.prime_idx           = CNT_W'(found_n);
        r.exhausted           = 1'b0;
        found_n++;
        cand_next = c + 1;
      end
    end
    prime_expect_q.push_back(r);
  endfunction

  // Request driver. A request is offered until it is taken; the next one is
  // put up right after a transfer, unless the sender decides to idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_prime(in_if.restart);
        n_accepted++;
        if (in_if.restart)
          n_restarts++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (request_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_if.valid   <= 1'b1;
          in_if.restart <= request_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each transfer on the result channel is checked against
  // the oldest prediction; ready is redrawn every cycle.
  always @(posedge clk) begin
    prime_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (prime_expect_q.size() == 0) begin
          $error("result with no request pending: prime %0d index %0d exhausted %0b",
                 out_if.prime, out_if.prime_index, out_if.exhausted);
          n_errors++;
        end else begin
          want = prime_expect_q.pop_front();
          if (out_if.prime !== want.prime) begin
            $error("prime: expected %0d, got %0d", want.prime, out_if.prime);
            n_errors++;
          end
          if (out_if.prime_index !== want.prime_idx) begin
            $error("prime_index: expected %0d, got %0d", want.prime_idx,
                   out_if.prime_index);
            n_errors++;
          end
          if (out_if.exhausted !== want.exhausted) begin
            $error("exhausted: expected %0b, got %0b", want.exhausted,
                   out_if.exhausted);
            n_errors++;
          end
          if (want.exhausted) begin
            n_exhausted++;
          end else begin
            n_primes++;
            if (want.prime_idx > max_idx_seen)
              max_idx_seen = want.prime_idx;
          end
        end
      end
      out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // The long hold-off: once the chosen segment starts, the result side stops
  // taking results while the driver keeps offering requests, so the output
  // register fills and the block has to stall its request channel.
  initial begin
    rx_hold = 1'b0;
    wait (phase_id == HOLD_SEGMENT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Hard limit on the run time, far beyond the slowest correct run.
  initial begin
    #(8 * 4_000_000);
    $display("status: fail");
    $finish;
  end

  task automatic push_request(bit restart);
    request_q.push_back(restart);
    n_pushed++;
  endtask

  // Waits until every queued request has been taken and every predicted
  // result has come back, then lets the block sit idle before returning.
  task automatic settle();
    do
      @(posedge clk);
    while (n_accepted != n_pushed || prime_expect_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  // Writes the limit register through a setup and an access cycle, then reads
  // it back. Only the low CNT_W bits of the data are kept by the register.
  task automatic write_limit(logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(REG_PRIME_LIMIT * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    limit_reg = int'(value[CNT_W-1:0]);
    n_limit_writes++;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    if (prdata[CNT_W-1:0] !== value[CNT_W-1:0]) begin
      $error("prime_limit: expected %0d, got %0d", value[CNT_W-1:0],
             prdata[CNT_W-1:0]);
      n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stimulus and end of run.
  initial begin
    int run_len;
    int seg_items;
    int lim;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.restart  = 1'b0;
    out_if.ready   = 1'b0;
    rst_n          = 1'b0;
    phase_id       = -1;
    tx_idle_pct    = 22;
    rx_idle_pct    = 81;
    found_n        = 0;
    cand_next      = CAND_START;
    limit_reg      = LIMIT_RESET;
    n_pushed       = 0;
    n_accepted     = 0;
    n_errors       = 0;
    n_primes       = 0;
    n_exhausted    = 0;
    n_restarts     = 0;
    n_limit_writes = 0;
    max_idx_seen   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening, first with the reset limit: the first primes, then a
    // restart in the middle of a run.
    repeat (5) push_request(1'b0);
    push_request(1'b1);
    repeat (2) push_request(1'b0);
    settle();

    // A limit of zero exhausts every request, with or without restart.
    write_limit(0);
    push_request(1'b0);
    push_request(1'b1);
    push_request(1'b0);
    settle();

    // A limit of one: a single prime, then exhaustion, then a fresh start.
    write_limit(1);
    push_request(1'b0);
    push_request(1'b0);
    push_request(1'b1);
    settle();

    // The largest limit lies above the table depth and is capped by it.
    write_limit(32'h0000_07FF);
    push_request(1'b0);
    push_request(1'b0);
    push_request(1'b1);
    settle();

    // Upper data bits set; the register keeps a limit of five, which this
    // run of requests reaches and passes.
    write_limit(32'hFFFF_F805);
    repeat (5) push_request(1'b0);
    settle();

    // Random part. Each segment gets its own limit and idle pattern; most
    // requests come as runs that start with a restart, some as noise.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0, 6, HOLD_SEGMENT: lim = LIMIT_RESET;
        2:                  lim = 2047;
        4:                  lim = 1;
        9:                  lim = 0;
        default:            lim = $urandom_range(2, 60);
      endcase
      write_limit(CFG_DATA_W'(lim));
      case (seg % 3)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 22;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      phase_id  = seg;
      seg_items = (lim == 0) ? 30 : SEGMENT_ITEMS;
      while (seg_items > 0) begin
        if ($urandom_range(7) == 0) begin
          run_len = $urandom_range(1, 6);
          repeat (run_len) push_request(1'($urandom_range(1)));
          seg_items -= run_len;
        end else begin
          run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 200)
                                             : $urandom_range(1, 40);
          push_request(1'b1);
          repeat (run_len) push_request(1'b0);
          seg_items -= run_len + 1;
        end
      end
      settle();
    end

    // Nothing more is expected; give any stray result time to show up.
    repeat (50) @(posedge clk);
    $display("covered %0d requests (%0d with restart) under %0d limit settings",
             n_accepted, n_restarts, n_limit_writes);
    $display("checked %0d primes up to index %0d and %0d exhausted replies",
             n_primes, max_idx_seen, n_exhausted);
    if (n_errors == 0 && prime_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ prime_gen_trial_by_primes.f @@
src/pgtp_pkg.sv
src/pgtp_if.sv
src/pgtp_table.sv
src/pgtp_divider.sv
src/prime_gen_trial_by_primes.sv
tb/prime_gen_trial_by_primes_test.sv
